// ===== src/mmpa_pkg.sv =====
package mmpa_pkg;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam int COEF_W = 16;

	localparam int SQ_STEPS = 32;
	localparam int SQ_W     = 64;
	localparam int RHO_W    = 32;
	localparam int CQ_W     = 31;
	localparam logic [CQ_W-1:0] CQ_ONE = CQ_W'(1) << (CQ_W - 1);

	localparam int KP_W  = 49;
	localparam int NP_W  = 50;
	localparam int PRD_W = 100;
	localparam int MAG_W = 96;
	localparam int Q_W   = 32;
	localparam int N_W   = 126;
	localparam int CO_SH = 14;
	localparam int CO_RW = 96;

	typedef enum logic [2:0] {
		REG_A_RE = 3'd0,
		REG_A_IM = 3'd1,
		REG_B_RE = 3'd2,
		REG_B_IM = 3'd3,
		REG_C_RE = 3'd4,
		REG_C_IM = 3'd5,
		REG_D_RE = 3'd6,
		REG_D_IM = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] a_re;
		logic signed [COEF_W-1:0] a_im;
		logic signed [COEF_W-1:0] b_re;
		logic signed [COEF_W-1:0] b_im;
		logic signed [COEF_W-1:0] c_re;
		logic signed [COEF_W-1:0] c_im;
		logic signed [COEF_W-1:0] d_re;
		logic signed [COEF_W-1:0] d_im;
	} coef_t;

	localparam coef_t COEF_RESET = '{
		a_re: 16'sd11585,
		a_im: 16'sd0,
		b_re: 16'sd0,
		b_im: -16'sd11585,
		c_re: 16'sd0,
		c_im: -16'sd11585,
		d_re: 16'sd11585,
		d_im: 16'sd0
	};

	typedef struct packed {
		logic signed [31:0] x_in;
		logic signed [31:0] y_in;
		logic signed [31:0] z_in;
	} point_t;

	typedef struct packed {
		logic signed [31:0] x_out;
		logic signed [31:0] y_out;
		logic signed [31:0] z_out;
		logic               pole_hit;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic [31:0]        ax;
		logic [31:0]        ay;
		logic               xneg;
		logic               yneg;
		logic signed [31:0] z;
	} sq_side_t;

	typedef struct packed {
		logic signed [31:0] z;
		logic               xneg;
		logic               yneg;
	} cq_side_t;

	typedef struct packed {
		logic [2:0] ovf;
		logic [2:0] neg;
	} co_side_t;

endpackage

// ===== src/mobius_map_point_about_axis.sv =====
// Channel   Direction  Handshake              Payload
// point     in         pt_valid / pt_ready    pt_data  (mmpa_pkg::point_t)
// result    out        res_valid / res_ready  res_data (mmpa_pkg::result_t)
// config    in         APB psel/penable       paddr, pwdata, prdata
//
// One request per cycle while no result waits; the data passes the 32-cell square-root
// chain, the 31-cell azimuth divider chain and the 32-cell output divider chain.
// Reset clears all valid bits and the input skid; coefficients return to the
// upper-half-space to ball map.
// A waiting result holds the whole pipeline; one request parks in the input skid.
module mobius_map_point_about_axis (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pt_valid,
	output logic                        pt_ready,
	input  mmpa_pkg::point_t            pt_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output mmpa_pkg::result_t           res_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mmpa_pkg::APB_AW-1:0] paddr,
	input  logic [mmpa_pkg::APB_DW-1:0] pwdata,
	output logic [mmpa_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	localparam int SQN  = mmpa_pkg::SQ_STEPS;
	localparam int SQW  = mmpa_pkg::SQ_W;
	localparam int RHW  = mmpa_pkg::RHO_W;
	localparam int CQW  = mmpa_pkg::CQ_W;
	localparam int KPW  = mmpa_pkg::KP_W;
	localparam int NPW  = mmpa_pkg::NP_W;
	localparam int PDW  = mmpa_pkg::PRD_W;
	localparam int MGW  = mmpa_pkg::MAG_W;
	localparam int QW   = mmpa_pkg::Q_W;
	localparam int NW   = mmpa_pkg::N_W;
	localparam int CRW  = mmpa_pkg::CO_RW;
	localparam int HIW  = NW - mmpa_pkg::CO_SH - QW;
	localparam int NST  = 1 + SQN + CQW + 9 + QW + 1;

	typedef struct packed {
		logic signed [51:0] ll;
		logic signed [50:0] hl;
		logic signed [50:0] lh;
		logic signed [49:0] hh;
	} part_t;

	typedef struct packed {
		logic [CQW-1:0] cx;
		logic [CQW-1:0] cy;
		logic           xneg;
		logic           yneg;
	} aux_t;

	function automatic part_t split_mul(input logic signed [NPW-1:0] a,
		input logic signed [NPW-1:0] b);
		part_t p;
		p.ll = $signed({1'b0, a[24:0]}) * $signed({1'b0, b[24:0]});
		p.hl = $signed(a[49:25]) * $signed({1'b0, b[24:0]});
		p.lh = $signed({1'b0, a[24:0]}) * $signed(b[49:25]);
		p.hh = $signed(a[49:25]) * $signed(b[49:25]);
		return p;
	endfunction

	function automatic logic signed [PDW-1:0] join_mul(input part_t p);
		return (PDW'(p.hh) <<< 50) + (PDW'(p.hl) <<< 25) + (PDW'(p.lh) <<< 25)
			+ PDW'(p.ll);
	endfunction

	mmpa_pkg::coef_t coef;

	mmpa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	logic             en;
	logic             skid_vld_q;
	logic             pt_fire;
	logic             pick_vld;
	mmpa_pkg::point_t skid_q;
	mmpa_pkg::point_t pick;
	logic [NST-1:0]   vld_q;

	assign en       = !res_valid || res_ready;
	assign pt_ready = !skid_vld_q;
	assign pt_fire  = pt_valid && pt_ready;
	assign pick_vld = skid_vld_q || pt_fire;
	assign pick     = skid_vld_q ? skid_q : pt_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (pt_fire) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && pt_fire) begin
			skid_q <= pt_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], pick_vld};
		end
	end

	assign res_valid = vld_q[NST-1];

	logic [31:0]          ax_c;
	logic [31:0]          ay_c;
	logic [SQW-1:0]       n_s0;
	mmpa_pkg::sq_side_t   side_s0;

	assign ax_c = pick.x_in[31] ? 32'(-pick.x_in) : 32'(pick.x_in);
	assign ay_c = pick.y_in[31] ? 32'(-pick.y_in) : 32'(pick.y_in);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s0         <= ({32'b0, ax_c} * {32'b0, ax_c}) + ({32'b0, ay_c} * {32'b0, ay_c});
			side_s0.ax   <= ax_c;
			side_s0.ay   <= ay_c;
			side_s0.xneg <= pick.x_in[31];
			side_s0.yneg <= pick.y_in[31];
			side_s0.z    <= pick.z_in;
		end
	end

	logic [SQW-1:0]     sq_n    [0:SQN];
	logic [SQW-1:0]     sq_res  [0:SQN];
	mmpa_pkg::sq_side_t sq_side [0:SQN];

	assign sq_n[0]    = n_s0;
	assign sq_res[0]  = '0;
	assign sq_side[0] = side_s0;

	for (genvar k = 0; k < SQN; k++) begin : g_sq
		mmpa_sqrt_cell #(.STEP(k)) u_cell (
			.clk    (clk),
			.en     (en),
			.n_i    (sq_n[k]),
			.res_i  (sq_res[k]),
			.side_i (sq_side[k]),
			.n_o    (sq_n[k+1]),
			.res_o  (sq_res[k+1]),
			.side_o (sq_side[k+1])
		);
	end

	logic [1:0][RHW-1:0] dv_rem  [0:CQW];
	logic [1:0][CQW-1:0] dv_acc  [0:CQW];
	logic [RHW-1:0]      dv_div  [0:CQW];
	mmpa_pkg::cq_side_t  dv_side [0:CQW];

	assign dv_rem[0][0]    = {1'b0, sq_side[SQN].ax[31:1]};
	assign dv_rem[0][1]    = {1'b0, sq_side[SQN].ay[31:1]};
	assign dv_acc[0][0]    = {sq_side[SQN].ax[0], {(CQW-1){1'b0}}};
	assign dv_acc[0][1]    = {sq_side[SQN].ay[0], {(CQW-1){1'b0}}};
	assign dv_div[0]       = sq_res[SQN][RHW-1:0];
	assign dv_side[0].z    = sq_side[SQN].z;
	assign dv_side[0].xneg = sq_side[SQN].xneg;
	assign dv_side[0].yneg = sq_side[SQN].yneg;

	for (genvar k = 0; k < CQW; k++) begin : g_dv
		mmpa_div_cell #(
			.RW     (RHW),
			.QW     (CQW),
			.LANES  (2),
			.SIDE_T (mmpa_pkg::cq_side_t)
		) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (dv_rem[k]),
			.acc_i  (dv_acc[k]),
			.div_i  (dv_div[k]),
			.side_i (dv_side[k]),
			.rem_o  (dv_rem[k+1]),
			.acc_o  (dv_acc[k+1]),
			.div_o  (dv_div[k+1]),
			.side_o (dv_side[k+1])
		);
	end

	logic                    rho_zero;
	logic signed [RHW:0]     rho_sx;
	logic signed [31:0]      z_e;
	logic signed [KPW-1:0]   kp_s1 [8];
	aux_t                    aux_s1, aux_s2, aux_s3, aux_s4, aux_s5;
	logic signed [NPW-1:0]   nr_s2, ni_s2, dr_s2, di_s2;
	part_t                   pt_s3 [6];
	logic signed [PDW-1:0]   pf_s4 [6];
	logic signed [PDW-1:0]   pr_s5, pi_s5, dd_s5;
	logic [MGW-1:0]          mag_s6 [3];
	logic [CQW-1:0]          cq_s6  [3];
	logic [2:0]              neg_s6, neg_s7, neg_s8;
	logic [MGW-1:0]          dd_s6, dd_s7, dd_s8;
	logic [62:0]             cp_s7  [3][3];
	logic [NW-1:0]           nn_s8  [3];

	assign rho_zero = dv_div[CQW] == '0;
	assign rho_sx   = $signed({1'b0, dv_div[CQW]});
	assign z_e      = dv_side[CQW].z;

	always_ff @(posedge clk) begin
		if (en) begin
			kp_s1[0]    <= coef.a_re * rho_sx;
			kp_s1[1]    <= coef.a_im * z_e;
			kp_s1[2]    <= coef.a_re * z_e;
			kp_s1[3]    <= coef.a_im * rho_sx;
			kp_s1[4]    <= coef.c_re * rho_sx;
			kp_s1[5]    <= coef.c_im * z_e;
			kp_s1[6]    <= coef.c_re * z_e;
			kp_s1[7]    <= coef.c_im * rho_sx;
			aux_s1.cx   <= rho_zero ? mmpa_pkg::CQ_ONE : dv_acc[CQW][0];
			aux_s1.cy   <= rho_zero ? '0 : dv_acc[CQW][1];
			aux_s1.xneg <= dv_side[CQW].xneg;
			aux_s1.yneg <= dv_side[CQW].yneg;

			nr_s2  <= NPW'(kp_s1[0]) - NPW'(kp_s1[1]) + (NPW'(coef.b_re) <<< 16);
			ni_s2  <= NPW'(kp_s1[2]) + NPW'(kp_s1[3]) + (NPW'(coef.b_im) <<< 16);
			dr_s2  <= NPW'(kp_s1[4]) - NPW'(kp_s1[5]) + (NPW'(coef.d_re) <<< 16);
			di_s2  <= NPW'(kp_s1[6]) + NPW'(kp_s1[7]) + (NPW'(coef.d_im) <<< 16);
			aux_s2 <= aux_s1;

			pt_s3[0] <= split_mul(nr_s2, dr_s2);
			pt_s3[1] <= split_mul(ni_s2, di_s2);
			pt_s3[2] <= split_mul(ni_s2, dr_s2);
			pt_s3[3] <= split_mul(nr_s2, di_s2);
			pt_s3[4] <= split_mul(dr_s2, dr_s2);
			pt_s3[5] <= split_mul(di_s2, di_s2);
			aux_s3   <= aux_s2;

			for (int i = 0; i < 6; i++) begin
				pf_s4[i] <= join_mul(pt_s3[i]);
			end
			aux_s4 <= aux_s3;

			pr_s5  <= pf_s4[0] + pf_s4[1];
			pi_s5  <= pf_s4[2] - pf_s4[3];
			dd_s5  <= pf_s4[4] + pf_s4[5];
			aux_s5 <= aux_s4;

			mag_s6[0] <= MGW'(pr_s5[PDW-1] ? -pr_s5 : pr_s5);
			mag_s6[1] <= MGW'(pr_s5[PDW-1] ? -pr_s5 : pr_s5);
			mag_s6[2] <= MGW'(pi_s5[PDW-1] ? -pi_s5 : pi_s5);
			cq_s6[0]  <= aux_s5.cx;
			cq_s6[1]  <= aux_s5.cy;
			cq_s6[2]  <= mmpa_pkg::CQ_ONE;
			neg_s6    <= {pi_s5[PDW-1], pr_s5[PDW-1] ^ aux_s5.yneg,
				pr_s5[PDW-1] ^ aux_s5.xneg};
			dd_s6     <= dd_s5[MGW-1:0];

			for (int l = 0; l < 3; l++) begin
				for (int j = 0; j < 3; j++) begin
					cp_s7[l][j] <= {31'b0, mag_s6[l][32*j +: 32]} * {32'b0, cq_s6[l]};
				end
			end
			neg_s7 <= neg_s6;
			dd_s7  <= dd_s6;

			for (int l = 0; l < 3; l++) begin
				nn_s8[l] <= NW'(cp_s7[l][0]) + (NW'(cp_s7[l][1]) << 32)
					+ (NW'(cp_s7[l][2]) << 64);
			end
			neg_s8 <= neg_s7;
			dd_s8  <= dd_s7;
		end
	end

	logic [2:0][CRW-1:0] cd_rem  [0:QW];
	logic [2:0][QW-1:0]  cd_acc  [0:QW];
	logic [CRW-1:0]      cd_div  [0:QW];
	mmpa_pkg::co_side_t  cd_side [0:QW];
	logic [2:0][CRW-1:0] rem_s9;
	logic [2:0][QW-1:0]  acc_s9;
	logic [CRW-1:0]      dd_s9;
	mmpa_pkg::co_side_t  side_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rem_s9[l]      <= CRW'(nn_s8[l][NW-1 -: HIW]);
				acc_s9[l]      <= nn_s8[l][mmpa_pkg::CO_SH +: QW];
				side_s9.ovf[l] <= CRW'(nn_s8[l][NW-1 -: HIW]) >= dd_s8;
			end
			side_s9.neg <= neg_s8;
			dd_s9       <= dd_s8;
		end
	end

	assign cd_rem[0]  = rem_s9;
	assign cd_acc[0]  = acc_s9;
	assign cd_div[0]  = dd_s9;
	assign cd_side[0] = side_s9;

	for (genvar k = 0; k < QW; k++) begin : g_cd
		mmpa_div_cell #(
			.RW     (CRW),
			.QW     (QW),
			.LANES  (3),
			.SIDE_T (mmpa_pkg::co_side_t)
		) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (cd_rem[k]),
			.acc_i  (cd_acc[k]),
			.div_i  (cd_div[k]),
			.side_i (cd_side[k]),
			.rem_o  (cd_rem[k+1]),
			.acc_o  (cd_acc[k+1]),
			.div_o  (cd_div[k+1]),
			.side_o (cd_side[k+1])
		);
	end

	logic [QW-1:0]     lim_c [3];
	logic [QW-1:0]     mg_c  [3];
	logic [QW-1:0]     val_c [3];
	logic [2:0]        sat_c;
	logic              pole_c;
	mmpa_pkg::result_t res_q;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			lim_c[l] = cd_side[QW].neg[l] ? 32'h8000_0000 : 32'h7fff_ffff;
			sat_c[l] = cd_side[QW].ovf[l] || (cd_acc[QW][l] > lim_c[l]);
			mg_c[l]  = sat_c[l] ? lim_c[l] : cd_acc[QW][l];
			val_c[l] = cd_side[QW].neg[l] ? -mg_c[l] : mg_c[l];
		end
	end

	assign pole_c = cd_div[QW] == '0;

	always_ff @(posedge clk) begin
		if (en) begin
			if (pole_c) begin
				res_q.x_out     <= 32'sh7fff_ffff;
				res_q.y_out     <= 32'sh7fff_ffff;
				res_q.z_out     <= 32'sh7fff_ffff;
				res_q.pole_hit  <= 1'b1;
				res_q.saturated <= 1'b1;
			end else begin
				res_q.x_out     <= $signed(val_c[0]);
				res_q.y_out     <= $signed(val_c[1]);
				res_q.z_out     <= $signed(val_c[2]);
				res_q.pole_hit  <= 1'b0;
				res_q.saturated <= |sat_c;
			end
		end
	end

	assign res_data = res_q;

`ifndef SYNTH
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !en |=> skid_vld_q && $stable(skid_q))
		else $error("parked request lost while stalled");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(pt_fire) && !$past(en))
		else $error("skid filled without a stall");

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pt_ready) |-> $past(!en))
		else $error("pt_ready dropped while pipeline advanced");

	a_pole_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.pole_hit |-> res_data.saturated
			&& res_data.x_out == 32'sh7fff_ffff && res_data.z_out == 32'sh7fff_ffff)
		else $error("pole result not clamped");
`endif

endmodule

// ===== src/mmpa_regs.sv =====
module mmpa_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mmpa_pkg::APB_AW-1:0] paddr,
	input  logic [mmpa_pkg::APB_DW-1:0] pwdata,
	output logic [mmpa_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output mmpa_pkg::coef_t             coef
);

	mmpa_pkg::coef_t    coef_q;
	mmpa_pkg::reg_idx_t idx;
	logic               wr;
	logic [mmpa_pkg::COEF_W-1:0] rd;
	logic [mmpa_pkg::COEF_W-1:0] wv;

	assign idx    = mmpa_pkg::reg_idx_t'(paddr[mmpa_pkg::APB_AW-1:2]);
	assign wr     = psel && penable && pwrite;
	assign wv     = pwdata[mmpa_pkg::COEF_W-1:0];
	assign pready = 1'b1;
	assign coef   = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= mmpa_pkg::COEF_RESET;
		end else if (wr) begin
			case (idx)
				mmpa_pkg::REG_A_RE: coef_q.a_re <= $signed(wv);
				mmpa_pkg::REG_A_IM: coef_q.a_im <= $signed(wv);
				mmpa_pkg::REG_B_RE: coef_q.b_re <= $signed(wv);
				mmpa_pkg::REG_B_IM: coef_q.b_im <= $signed(wv);
				mmpa_pkg::REG_C_RE: coef_q.c_re <= $signed(wv);
				mmpa_pkg::REG_C_IM: coef_q.c_im <= $signed(wv);
				mmpa_pkg::REG_D_RE: coef_q.d_re <= $signed(wv);
				mmpa_pkg::REG_D_IM: coef_q.d_im <= $signed(wv);
				default: coef_q <= coef_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			mmpa_pkg::REG_A_RE: rd = coef_q.a_re;
			mmpa_pkg::REG_A_IM: rd = coef_q.a_im;
			mmpa_pkg::REG_B_RE: rd = coef_q.b_re;
			mmpa_pkg::REG_B_IM: rd = coef_q.b_im;
			mmpa_pkg::REG_C_RE: rd = coef_q.c_re;
			mmpa_pkg::REG_C_IM: rd = coef_q.c_im;
			mmpa_pkg::REG_D_RE: rd = coef_q.d_re;
			mmpa_pkg::REG_D_IM: rd = coef_q.d_im;
			default: rd = '0;
		endcase
	end

	assign prdata = {{(mmpa_pkg::APB_DW - mmpa_pkg::COEF_W){1'b0}}, rd};

endmodule

// ===== src/mmpa_sqrt_cell.sv =====
module mmpa_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [mmpa_pkg::SQ_W-1:0]     n_i,
	input  logic [mmpa_pkg::SQ_W-1:0]     res_i,
	input  mmpa_pkg::sq_side_t            side_i,
	output logic [mmpa_pkg::SQ_W-1:0]     n_o,
	output logic [mmpa_pkg::SQ_W-1:0]     res_o,
	output mmpa_pkg::sq_side_t            side_o
);

	localparam logic [mmpa_pkg::SQ_W-1:0] BIT =
		mmpa_pkg::SQ_W'(1) << (mmpa_pkg::SQ_W - 2 - 2 * STEP);

	logic [mmpa_pkg::SQ_W-1:0] trial;
	logic [mmpa_pkg::SQ_W-1:0] n_q;
	logic [mmpa_pkg::SQ_W-1:0] res_q;
	mmpa_pkg::sq_side_t        side_q;

	assign trial = res_i + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if (n_i >= trial) begin
				n_q   <= n_i - trial;
				res_q <= (res_i >> 1) + BIT;
			end else begin
				n_q   <= n_i;
				res_q <= res_i >> 1;
			end
			side_q <= side_i;
		end
	end

	assign n_o    = n_q;
	assign res_o  = res_q;
	assign side_o = side_q;

endmodule

// ===== src/mmpa_div_cell.sv =====
module mmpa_div_cell #(
	parameter int  RW     = 32,
	parameter int  QW     = 31,
	parameter int  LANES  = 1,
	parameter type SIDE_T = logic
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [LANES-1:0][RW-1:0]   rem_i,
	input  logic [LANES-1:0][QW-1:0]   acc_i,
	input  logic [RW-1:0]              div_i,
	input  SIDE_T                      side_i,
	output logic [LANES-1:0][RW-1:0]   rem_o,
	output logic [LANES-1:0][QW-1:0]   acc_o,
	output logic [RW-1:0]              div_o,
	output SIDE_T                      side_o
);

	logic [LANES-1:0][RW:0]   trial;
	logic [LANES-1:0][RW-1:0] rem_d;
	logic [LANES-1:0][QW-1:0] acc_d;
	logic [LANES-1:0][RW-1:0] rem_q;
	logic [LANES-1:0][QW-1:0] acc_q;
	logic [RW-1:0]            div_q;
	SIDE_T                    side_q;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			trial[l] = {rem_i[l], acc_i[l][QW-1]};
			if (trial[l] >= {1'b0, div_i}) begin
				rem_d[l] = RW'(trial[l] - {1'b0, div_i});
				acc_d[l] = {acc_i[l][QW-2:0], 1'b1};
			end else begin
				rem_d[l] = trial[l][RW-1:0];
				acc_d[l] = {acc_i[l][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_d;
			acc_q  <= acc_d;
			div_q  <= div_i;
			side_q <= side_i;
		end
	end

	assign rem_o  = rem_q;
	assign acc_o  = acc_q;
	assign div_o  = div_q;
	assign side_o = side_q;

endmodule
